@@ rtl/bts_pkg.sv @@
// Shared types and constants of the binary thinning sub-pass block.
// Used by the configuration interface, the window logic and the top level.
package bts_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_PASS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Register field widths and geometry limits.
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Rule constants of the thinning test.
  localparam int B_LOW  = 2;
  localparam int B_HIGH = 6;
  localparam int A_WANT = 1;

  // One result word.
  typedef struct packed {
    logic pixel_out;
    logic removed;
    logic frame_end;
    logic frame_changed;
  } res_t;

  // Control passed from the pipeline to the window logic.
  typedef struct packed {
    logic shift;     // the item in the read stage moves on this edge
    logic clear;     // stream restart after a geometry write
    logic emit;      // the item produces a result
    logic interior;  // its output pixel lies off the image border
    logic fend;      // its output pixel is the last of a frame
    logic sub_pass;  // which product pair applies
  } win_ctl_t;

endpackage

@@ rtl/bts_pix_if.sv @@
// Input pixel channel: valid, ready and one binary pixel per word.
// Depends on nothing else.
interface bts_pix_if;
  logic valid;
  logic ready;
  logic pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

@@ rtl/bts_res_if.sv @@
// Result channel: valid, ready and the four result fields of one word.
// Depends on nothing else.
interface bts_res_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic removed;
  logic frame_end;
  logic frame_changed;

  modport source (output valid, output pixel_out, output removed,
                  output frame_end, output frame_changed, input ready);
  modport sink (input valid, input pixel_out, input removed,
                input frame_end, input frame_changed, output ready);
endinterface

@@ rtl/bts_cfg_if.sv @@
// Configuration write channel: valid, ready, register index and data.
// Depends on bts_pkg for the index and data widths.
interface bts_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bts_pkg::CFG_IDX_W-1:0]   index;
  logic [bts_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/bts_line_buf.sv @@
// Column-indexed line buffer holding the two rows above the incoming pixel.
// One synchronous read port with registered data, one write port.
module bts_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data
);

  // Bit 1 holds the upper row, bit 0 the middle row.
  logic [1:0] mem [DEPTH];

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

@@ rtl/bts_window.sv @@
// 3x3 neighbourhood window, the Zhang-Suen removal test and the per-frame
// removal flag. Depends on bts_pkg for the control and result types.
module bts_window (
  input  logic              clk,
  input  logic              rst,
  input  bts_pkg::win_ctl_t ctl,
  input  logic [2:0]        col_bits,  // {new pixel, middle row, upper row}
  output bts_pkg::res_t     res
);

  // Newest column sits in bits 2:0, top row in the lowest bit of a column.
  logic [8:0] window;
  logic [8:0] window_next;
  logic       any_removed;
  logic       p2, p3, p4, p5, p6, p7, p8, p9, centre;
  logic [3:0] a_cnt;
  logic [3:0] b_cnt;
  logic       m1, m2;
  logic       rem;

  assign window_next = {window[5:0], col_bits};

  // Neighbours clockwise from north.
  assign p2     = window_next[3];
  assign p3     = window_next[0];
  assign p4     = window_next[1];
  assign p5     = window_next[2];
  assign p6     = window_next[5];
  assign p7     = window_next[8];
  assign p8     = window_next[7];
  assign p9     = window_next[6];
  assign centre = window_next[4];

  // Transition count and neighbour sum.
  always_comb begin
    a_cnt = 4'(!p2 && p3) + 4'(!p3 && p4) + 4'(!p4 && p5) + 4'(!p5 && p6)
          + 4'(!p6 && p7) + 4'(!p7 && p8) + 4'(!p8 && p9) + 4'(!p9 && p2);
    b_cnt = 4'(p2) + 4'(p3) + 4'(p4) + 4'(p5) + 4'(p6) + 4'(p7) + 4'(p8) + 4'(p9);
  end

  // Sub-pass products.
  always_comb begin
    if (ctl.sub_pass) begin
      m1 = p2 & p4 & p8;
      m2 = p2 & p6 & p8;
    end else begin
      m1 = p2 & p4 & p6;
      m2 = p4 & p6 & p8;
    end
  end

  assign rem = ctl.interior && centre && (a_cnt == 4'(bts_pkg::A_WANT))
            && (b_cnt >= 4'(bts_pkg::B_LOW)) && (b_cnt <= 4'(bts_pkg::B_HIGH))
            && !m1 && !m2;

  always_comb begin
    res.pixel_out     = centre && !rem;
    res.removed       = rem;
    res.frame_end     = ctl.fend;
    res.frame_changed = ctl.fend && (any_removed || rem);
  end

  // The window shifts once per item; a restart empties it.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      window <= '0;
    end else if (ctl.shift) begin
      window <= window_next;
    end
  end

  // Removal flag of the frame being output; cleared at its last pixel.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      any_removed <= 1'b0;
    end else if (ctl.shift && ctl.emit) begin
      if (ctl.fend) begin
        any_removed <= 1'b0;
      end else if (rem) begin
        any_removed <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/binary_thinning_subpass_top.sv @@
// Top level of the thinning sub-pass block: scan counters, read pipeline,
// output register. Depends on bts_pkg, the three channel interfaces,
// bts_line_buf and bts_window.
//
// Usage: binary pixels enter on the pixels channel in raster order, frames
// back to back. Each accepted word produces one result word on the results
// channel, except the first image_width+1 words after reset or after a
// geometry write, which only fill the line buffers. Result n belongs to the
// pixel accepted image_width+1 words earlier; append image_width+1 dummy
// words to flush the last frame. frame_end marks a frame's bottom-right
// pixel and frame_changed on it tells whether any pixel was removed.
// Throughput is one word per cycle; the limit is the single read and write
// port pair of the line buffer memory, read when a word is accepted and
// written back one stage later. The result word that an accepted word
// releases goes from the read stage to the output register. When the receiver
// stalls, the output register holds its word and the read stage takes one
// more word before the input side stops. Reset restores sub_pass 0, width
// 640, height 480 and restarts the stream; the line buffers need no
// clearing. Configuration is taken every cycle; a width or height write
// restarts the stream.
module binary_thinning_subpass_top #(
  parameter int MAX_WIDTH = 1024
) (
  input logic      clk,
  input logic      rst,
  bts_pix_if.sink   pixels,
  bts_res_if.source results,
  bts_cfg_if.sink   cfg
);

  localparam int MAX_W_EFF = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
  localparam int RST_W     = (bts_pkg::RESET_WIDTH < MAX_W_EFF) ?
                             bts_pkg::RESET_WIDTH : MAX_W_EFF;
  localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WU_W      = $clog2(MAX_W_EFF + 2);

  // Registers.
  logic                           sub_pass;
  logic [bts_pkg::WIDTH_W-1:0]    width;
  logic [bts_pkg::HEIGHT_W-1:0]   height;
  logic [bts_pkg::WIDTH_W-1:0]    width_next;
  logic [bts_pkg::HEIGHT_W-1:0]   height_next;
  logic                           cfg_write;
  logic                           geo_write;

  // Scan state.
  logic [CW-1:0]                  col;
  logic [bts_pkg::ROW_W-1:0]      row;
  logic [WU_W-1:0]                warmup;
  logic                           warm_done;
  logic                           col_wrap;
  logic                           row_wrap;

  // Pipeline.
  logic                           accept;
  logic                           adv_out;
  logic                           s1_take;
  logic                           s1_valid;
  logic                           s1_px;
  logic [CW-1:0]                  s1_col;
  logic                           s1_interior;
  logic                           s1_fend;
  logic                           s1_emit;
  logic [1:0]                     rd_data;
  logic                           out_valid;
  bts_pkg::res_t                  out_res;
  bts_pkg::res_t                  win_res;
  bts_pkg::win_ctl_t              win_ctl;

  // Configuration writes with saturation of the geometry.
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;
  assign geo_write = cfg_write && ((cfg.index == bts_pkg::REG_IMAGE_WIDTH)
                                || (cfg.index == bts_pkg::REG_IMAGE_HEIGHT));

  always_comb begin
    width_next = cfg.data[bts_pkg::WIDTH_W-1:0];
    if (32'(width_next) < bts_pkg::MIN_DIM) begin
      width_next = bts_pkg::WIDTH_W'(bts_pkg::MIN_DIM);
    end else if (32'(width_next) > MAX_W_EFF) begin
      width_next = bts_pkg::WIDTH_W'(MAX_W_EFF);
    end
    height_next = cfg.data[bts_pkg::HEIGHT_W-1:0];
    if (32'(height_next) < bts_pkg::MIN_DIM) begin
      height_next = bts_pkg::HEIGHT_W'(bts_pkg::MIN_DIM);
    end else if (32'(height_next) > bts_pkg::MAX_HEIGHT) begin
      height_next = bts_pkg::HEIGHT_W'(bts_pkg::MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_pass <= 1'b0;
      width    <= bts_pkg::WIDTH_W'(RST_W);
      height   <= bts_pkg::HEIGHT_W'(bts_pkg::RESET_HEIGHT);
    end else if (cfg_write) begin
      case (cfg.index)
        bts_pkg::REG_SUB_PASS:     sub_pass <= cfg.data[0];
        bts_pkg::REG_IMAGE_WIDTH:  width    <= width_next;
        bts_pkg::REG_IMAGE_HEIGHT: height   <= height_next;
        default: ;
      endcase
    end
  end

  // Handshake: the read stage drains into the output register.
  assign adv_out       = !out_valid || results.ready;
  assign s1_take       = s1_valid && adv_out;
  assign pixels.ready  = !s1_valid || adv_out;
  assign accept        = pixels.valid && pixels.ready;

  // Scan counters give the position of the next input pixel.
  assign col_wrap  = (32'(col) + 1) >= 32'(width);
  assign row_wrap  = (32'(row) + 1) >= 32'(height);
  assign warm_done = 32'(warmup) >= (32'(width) + 1);

  always_ff @(posedge clk) begin
    if (rst || geo_write) begin
      col    <= '0;
      row    <= '0;
      warmup <= '0;
    end else if (accept) begin
      if (!warm_done) begin
        warmup <= warmup + 1'b1;
      end
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Read stage. The output pixel lies one column back, or at the end of
  // the row before when this pixel opens a row, and one row further up.
  always_ff @(posedge clk) begin
    if (rst || geo_write) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= pixels.pixel_in;
      s1_col      <= col;
      s1_emit     <= warm_done;
      s1_interior <= (32'(col) >= 2) && (32'(row) >= 2);
      s1_fend     <= (col == '0) && (row == bts_pkg::ROW_W'(1));
    end
  end

  // Line buffers: read on acceptance, the rows move down on write-back.
  bts_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (s1_take),
    .wr_addr (s1_col),
    .wr_data ({rd_data[0], s1_px})
  );

  // Window and removal test.
  always_comb begin
    win_ctl.shift    = s1_take;
    win_ctl.clear    = geo_write;
    win_ctl.emit     = s1_emit;
    win_ctl.interior = s1_interior;
    win_ctl.fend     = s1_fend;
    win_ctl.sub_pass = sub_pass;
  end

  bts_window u_window (
    .clk      (clk),
    .rst      (rst),
    .ctl      (win_ctl),
    .col_bits ({s1_px, rd_data[0], rd_data[1]}),
    .res      (win_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= s1_emit;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_res <= win_res;
    end
  end

  assign results.valid         = out_valid;
  assign results.pixel_out     = out_res.pixel_out;
  assign results.removed       = out_res.removed;
  assign results.frame_end     = out_res.frame_end;
  assign results.frame_changed = out_res.frame_changed;

`ifndef NO_ASSERTIONS
  // A frame change is only reported on the last pixel of a frame.
  a_changed_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_res.frame_changed || out_res.frame_end))
    else $error("frame_changed without frame_end");

  // A removed pixel is never output as foreground.
  a_removed_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.removed |-> !out_res.pixel_out)
    else $error("removed pixel still set");

  // The read stage keeps its word while the output register is blocked.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !results.ready && !geo_write |=>
      s1_valid && $stable(s1_col))
    else $error("read stage lost a word under stall");

  // The column counter stays inside the configured row.
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    32'(col) < 32'(width))
    else $error("column position beyond image width");
`endif

endmodule

@@ verif/bts_thinning_checker.sv @@
// Scoreboard for the thinning sub-pass block: watches the pixel, result and
// configuration channels, predicts every result word and compares it field by field.
// Depends on bts_pkg and the three channel interfaces.
module bts_thinning_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic clk,
  input  logic rst,
  bts_pix_if   pixels,
  bts_res_if   results,
  bts_cfg_if   cfg,
  output int   fail_count,
  output int   pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies as the block uses them, already saturated.
  logic sub_pass_q;
  int   img_w;
  int   img_h;

  // Own copy of the stream state.
  logic       upper_row [MAX_WIDTH];
  logic       middle_row [MAX_WIDTH];
  logic [8:0] nbhd;
  int         col_pos;
  int         row_pos;
  int         warm_cnt;
  logic       any_removed;

  bts_pkg::res_t expected_q[$];
  bts_pkg::res_t next_word;
  bts_pkg::res_t want_word;
  int            errors = 0;
  int            word_cnt = 0;

  function automatic int clamp_dim(input int v, input int hi);
    return (v < bts_pkg::MIN_DIM) ? bts_pkg::MIN_DIM : ((v > hi) ? hi : v);
  endfunction

  // A geometry write or reset restarts the scan from the top left.
  task automatic clear_stream();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i] = 1'b0;
      middle_row[i] = 1'b0;
    end
    nbhd = '0;
    col_pos = 0;
    row_pos = 0;
    warm_cnt = 0;
    any_removed = 1'b0;
  endtask

  task automatic apply_write(input logic [bts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bts_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bts_pkg::REG_SUB_PASS: begin
        sub_pass_q = val[0];
      end
      bts_pkg::REG_IMAGE_WIDTH: begin
        img_w = clamp_dim(int'(val[bts_pkg::WIDTH_W-1:0]), MAX_WIDTH);
        clear_stream();
      end
      bts_pkg::REG_IMAGE_HEIGHT: begin
        img_h = clamp_dim(int'(val[bts_pkg::HEIGHT_W-1:0]), bts_pkg::MAX_HEIGHT);
        clear_stream();
      end
      default: begin
      end
    endcase
  endtask

  // Takes one pixel word; returns 1 with the result word it releases, which
  // belongs to the pixel taken image_width+1 words earlier.
  function automatic logic thin_step(input logic px, output bts_pkg::res_t word);
    int   c, r, cc, cr, back, trans, nsum;
    logic up, mid, centre, m1, m2;
    logic p [2:9];

    word = '0;
    c = col_pos;
    r = row_pos;
    if (c >= img_w) c = 0;
    if (r >= img_h) r = 0;

    // Line buffers shift down one row and the window moves one column east.
    up = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = px;
    nbhd = {nbhd[5:0], px, mid, up};

    col_pos = c + 1;
    row_pos = r;
    if (col_pos >= img_w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= img_h) row_pos = 0;
    end

    if (warm_cnt < img_w + 1) begin
      warm_cnt++;
      return 1'b0;
    end

    // Position of the pixel at the window centre.
    cc = (c == 0) ? img_w - 1 : c - 1;
    back = (c == 0) ? 2 : 1;
    cr = (r >= back) ? r - back : r + img_h - back;

    centre = nbhd[4];
    word.pixel_out = centre;
    if (cr != 0 && cr != img_h - 1 && cc != 0 && cc != img_w - 1) begin
      // Neighbours clockwise from north.
      p[2] = nbhd[3];
      p[3] = nbhd[0];
      p[4] = nbhd[1];
      p[5] = nbhd[2];
      p[6] = nbhd[5];
      p[7] = nbhd[8];
      p[8] = nbhd[7];
      p[9] = nbhd[6];
      trans = 0;
      nsum = 0;
      for (int i = 2; i <= 9; i++) begin
        if (!p[i] && p[(i == 9) ? 2 : i + 1]) trans++;
        nsum += p[i];
      end
      if (sub_pass_q) begin
        m1 = p[2] & p[4] & p[8];
        m2 = p[2] & p[6] & p[8];
      end else begin
        m1 = p[2] & p[4] & p[6];
        m2 = p[4] & p[6] & p[8];
      end
      if (centre && trans == bts_pkg::A_WANT && nsum >= bts_pkg::B_LOW
          && nsum <= bts_pkg::B_HIGH && !m1 && !m2) begin
        word.pixel_out = 1'b0;
        word.removed = 1'b1;
        any_removed = 1'b1;
      end
    end

    if (cr == img_h - 1 && cc == img_w - 1) begin
      word.frame_end = 1'b1;
      word.frame_changed = any_removed;
      any_removed = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s is %b, expected %b",
                                word_cnt, name, got, want));
  endtask

  // Everything is sampled at the rising edge, so values are those before the edge.
  always @(posedge clk) begin
    if (rst) begin
      sub_pass_q = 1'b0;
      img_w = bts_pkg::RESET_WIDTH;
      img_h = bts_pkg::RESET_HEIGHT;
      clear_stream();
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) apply_write(cfg.index, cfg.data);
      if (pixels.valid && pixels.ready) begin
        if (thin_step(pixels.pixel_in, next_word)) expected_q = {expected_q, next_word};
      end
      if (results.valid && results.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing expected", word_cnt));
        end else begin
          want_word = expected_q.pop_front();
          check_field("pixel_out", results.pixel_out, want_word.pixel_out);
          check_field("removed", results.removed, want_word.removed);
          check_field("frame_end", results.frame_end, want_word.frame_end);
          check_field("frame_changed", results.frame_changed, want_word.frame_changed);
        end
        word_cnt++;
      end
    end
    pending_words <= expected_q.size();
    fail_count <= errors;
  end

endmodule

@@ verif/tb_binary_thinning_subpass_top.sv @@
// Testbench top for the thinning sub-pass block: clock, reset, pixel and
// configuration stimulus, result back-pressure and the verdict.
// Depends on bts_pkg, the channel interfaces, the block and bts_thinning_checker.
module tb_binary_thinning_subpass_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH    = 1024;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_WORDS = 450;
  localparam int WIDE_WORDS   = 1060;
  localparam int TALL_WORDS   = 60;
  localparam int IDLE_PAUSE   = 8;
  localparam logic [bts_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {FILL_NOISE, FILL_BLOCK, FILL_CLEAR, FILL_SOLID, FILL_CORNER} fill_t;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY, RX_PERIODIC} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst;
  int       fail_count;
  int       pending_words;
  int       cycle_cnt = 0;
  int       img_w = bts_pkg::RESET_WIDTH;
  int       img_h = bts_pkg::RESET_HEIGHT;
  int       burst_left = 0;
  bit       steady = 1'b0;
  int       sent_words = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_hold = 0;
  int       rx_tick = 0;

  bts_pix_if pixels();
  bts_res_if results();
  bts_cfg_if cfg();

  binary_thinning_subpass_top #(.MAX_WIDTH(MAX_WIDTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixels),
    .results (results),
    .cfg     (cfg)
  );

  bts_thinning_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .pixels        (pixels),
    .results       (results),
    .cfg           (cfg),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result receiver: the stall pattern is chosen anew at random from open, random, bursty and periodic.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 256 == 255) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: begin
        results.ready <= 1'b1;
      end
      RX_RANDOM: begin
        results.ready <= ($urandom_range(0, 99) < 60);
      end
      RX_BURSTY: begin
        if (rx_hold == 0) begin
          results.ready <= !results.ready;
          rx_hold <= $urandom_range(1, 12);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
      default: begin
        results.ready <= (rx_tick % 5 != 0);
      end
    endcase
  end

  function automatic int clamp_dim(input int v, input int hi);
    return (v < bts_pkg::MIN_DIM) ? bts_pkg::MIN_DIM : ((v > hi) ? hi : v);
  endfunction

  // Sends one pixel word; bursts of random length are separated by gaps
  // unless the current phase runs steady.
  task automatic send_pixel(input logic px);
    if (burst_left == 0) begin
      if (!steady) begin
        pixels.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    pixels.valid <= 1'b1;
    pixels.pixel_in <= px;
    @(posedge clk);
    while (!pixels.ready) @(posedge clk);
    sent_words++;
  endtask

  // Stops sending and waits until every predicted word has come back.
  task automatic wait_idle();
    pixels.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Leaves valid high so that writes can follow back to back.
  task automatic write_reg(input logic [bts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bts_pkg::CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // Sets the sub-pass and, with restart, the geometry, once the block is idle.
  // A write to the spare index goes first; the block must ignore it.
  task automatic setup_phase(input logic sp, input bit restart,
                             input logic [bts_pkg::CFG_DATA_W-1:0] w_raw,
                             input logic [bts_pkg::CFG_DATA_W-1:0] h_raw);
    logic [bts_pkg::CFG_DATA_W-1:0] junk;
    junk = bts_pkg::CFG_DATA_W'($urandom);
    wait_idle();
    write_reg(REG_SPARE, junk);
    write_reg(bts_pkg::REG_SUB_PASS, {junk[bts_pkg::CFG_DATA_W-1:1], sp});
    if (restart) begin
      write_reg(bts_pkg::REG_IMAGE_WIDTH, w_raw);
      write_reg(bts_pkg::REG_IMAGE_HEIGHT, h_raw);
      img_w = clamp_dim(int'(w_raw[bts_pkg::WIDTH_W-1:0]), MAX_WIDTH);
      img_h = clamp_dim(int'(h_raw), bts_pkg::MAX_HEIGHT);
    end
    cfg.valid <= 1'b0;
    steady = ($urandom_range(0, 3) == 0);
  endtask

  // One frame of the current geometry in raster order.
  task automatic send_frame(input fill_t fill);
    int   r0, r1, c0, c1, density;
    logic px;
    density = $urandom_range(15, 85);
    r0 = $urandom_range(0, img_h - 1);
    r1 = $urandom_range(r0, img_h - 1);
    c0 = $urandom_range(0, img_w - 1);
    c1 = $urandom_range(c0, img_w - 1);
    for (int r = 0; r < img_h; r++) begin
      for (int c = 0; c < img_w; c++) begin
        case (fill)
          FILL_NOISE:  px = ($urandom_range(0, 99) < density);
          FILL_BLOCK:  px = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ^
                            ($urandom_range(0, 99) < 4);
          FILL_CLEAR:  px = 1'b0;
          FILL_SOLID:  px = 1'b1;
          default:     px = (r >= img_h / 2 && c >= img_w / 2);
        endcase
        send_pixel(px);
      end
    end
  endtask

  // A run of noise pixels shorter than a frame.
  task automatic send_noise(input int count);
    repeat (count) send_pixel(1'($urandom_range(0, 1)));
  endtask

  // Dummy words that push the last frame out; their values never matter.
  task automatic flush_stream();
    repeat (img_w + 1) send_pixel(1'($urandom_range(0, 1)));
  endtask

  initial begin
    fill_t                          fill;
    int                             random_start;
    bit                             first_phase;
    logic [bts_pkg::CFG_DATA_W-1:0] w_raw;
    logic [bts_pkg::CFG_DATA_W-1:0] h_raw;

    rst = 1'b1;
    pixels.valid = 1'b0;
    pixels.pixel_in = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = bts_pkg::REG_SUB_PASS;
    cfg.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Smallest image: width written as zero with its top bits set, height
    // below the minimum. A solid frame keeps its centre, the corner shape
    // loses it under both sub-passes.
    setup_phase(1'b1, 1'b1, 13'h1800, 13'd1);
    send_frame(FILL_SOLID);
    send_frame(FILL_CORNER);
    setup_phase(1'b0, 1'b0, '0, '0);
    send_frame(FILL_CORNER);
    flush_stream();

    // Widest image: an all-ones width saturates to the line buffer depth.
    // A little more than the warmup shows the length of a row.
    setup_phase(1'($urandom_range(0, 1)), 1'b1, 13'h07FF, 13'd3);
    send_noise(WIDE_WORDS);

    // Tallest image: an all-ones height saturates to the row limit.
    setup_phase(1'($urandom_range(0, 1)), 1'b1, 13'd3, 13'h1FFF);
    send_noise(TALL_WORDS);

    // Random phases, mostly small images, some with only a sub-pass change.
    // The first one always sets a small geometry.
    random_start = sent_words;
    first_phase = 1'b1;
    while (sent_words - random_start < RANDOM_WORDS) begin
      case ($urandom_range(0, 7))
        0:       w_raw = bts_pkg::CFG_DATA_W'($urandom_range(0, 2));
        1:       w_raw = bts_pkg::CFG_DATA_W'($urandom_range(13, 40));
        2:       w_raw = {2'($urandom_range(1, 3)), 11'($urandom_range(0, 12))};
        default: w_raw = bts_pkg::CFG_DATA_W'($urandom_range(3, 12));
      endcase
      if ($urandom_range(0, 5) == 0) h_raw = bts_pkg::CFG_DATA_W'($urandom_range(0, 2));
      else h_raw = bts_pkg::CFG_DATA_W'($urandom_range(3, 10));
      setup_phase(1'($urandom_range(0, 1)), first_phase || ($urandom_range(0, 3) != 0),
                  w_raw, h_raw);
      first_phase = 1'b0;
      repeat ($urandom_range(1, 3)) begin
        fill = fill_t'($urandom_range(0, 4));
        send_frame(fill);
      end
      flush_stream();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
